// File: sv/tft_pkg.sv
// Shared types, codes and helper functions for the texture footprint tracker.
// No dependencies; every other file refers to this package by scoped names.
package tft_pkg;

  // Command codes
  typedef enum logic [1:0] {
    CMD_CREATE   = 2'd0,
    CMD_RELEASE  = 2'd1,
    CMD_COMPRESS = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_MISS  = 2'd2,
    ST_UNUSED = 2'd3
  } status_e;

  // Format codes that matter to the logic
  localparam logic [3:0] FMT_BC1     = 4'd1;
  localparam logic [3:0] FMT_BC1B    = 4'd2;
  localparam logic [3:0] FMT_BC3     = 4'd4;
  localparam logic [3:0] FMT_BC7     = 4'd7;
  localparam logic [3:0] FMT_BC_LAST = 4'd8;
  localparam logic [3:0] FMT_BC2     = 4'd3;
  localparam logic [3:0] FMT_RGBA8   = 4'd9;
  localparam logic [3:0] FMT_BGRA8   = 4'd11;
  localparam logic [3:0] FMT_RGBA16F = 4'd12;
  localparam logic [3:0] FMT_RGBA32F = 4'd13;

  // Compression levels
  localparam logic [2:0] LVL_BC1     = 3'd0;
  localparam logic [2:0] LVL_BC3     = 3'd1;
  localparam logic [2:0] LVL_BC7     = 3'd2;
  localparam logic [2:0] LVL_QUARTER = 3'd3;

  localparam logic [14:0] DIM_SAT    = 15'd32764;
  localparam logic [14:0] DIM_MIN    = 15'd4;
  localparam logic [14:0] MIN_DIM_RST = 15'd64;
  localparam logic [43:0] SIZE_MAX   = {44{1'b1}};

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] tex_id;
    logic [14:0] width;
    logic [14:0] height;
    logic [3:0]  mip_cnt;
    logic [11:0] slice_cnt;
    logic [3:0]  format;
    logic [2:0]  bind_bits;
    logic        cpu_write;
    logic [2:0]  comp_level;
    logic [14:0] req_w;
    logic [14:0] req_h;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [43:0] byte_size;
    logic        candidate;
    logic [14:0] new_width;
    logic [14:0] new_height;
    logic [3:0]  new_format;
    logic [43:0] comp_size;
    logic [43:0] saved_bytes;
  } out_item_t;

  // Table record: comp, size, shape (fmt, arr, mips), dims (h, w)
  typedef struct packed {
    logic [3:0]  comp;
    logic [43:0] size;
    logic [3:0]  fmt;
    logic [11:0] arr;
    logic [3:0]  mips;
    logic [14:0] h;
    logic [14:0] w;
  } rec_t;

  // Controller to datapath commands
  typedef struct packed {
    logic take;
    logic srch_start;
    logic srch_run;
    logic sz_step_a;
    logic sz_step_b;
    logic rd_last;
    logic rel_write;
    logic rd_rec;
    logic cp_dim;
    logic create_fin;
    logic cp_fin;
    logic miss_fin;
    logic zero_fin;
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [1:0] cmd;
    logic       srch_hit;
    logic       srch_miss;
    logic       sz_done;
  } dp_stat_t;

  // Round up to a multiple of 4, saturating
  function automatic logic [14:0] round4(input logic [14:0] v);
    logic [15:0] r;
    r = ({1'b0, v} + 16'd3) & ~16'd3;
    return (r > {1'b0, DIM_SAT}) ? DIM_SAT : r[14:0];
  endfunction

  // Half or quarter size, at least 4
  function automatic logic [14:0] shrink(input logic [14:0] v, input logic quarter);
    logic [14:0] r;
    r = round4(quarter ? (v >> 2) : (v >> 1));
    return (r < DIM_MIN) ? DIM_MIN : r;
  endfunction

endpackage

// File: sv/tft_if.sv
// Valid/ready channel interfaces for input and result items.
// Depends on tft_pkg for the payload types.
interface tft_in_if;
  logic              valid;
  logic              ready;
  tft_pkg::in_item_t item;
  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface tft_out_if;
  logic               valid;
  logic               ready;
  tft_pkg::out_item_t item;
  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

// File: sv/tft_ctrl.sv
// Controller state machine for the texture footprint tracker.
// Depends on tft_pkg; drives ctl_cmd_t into tft_dp and reads dp_stat_t.
module tft_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  logic [1:0]          in_cmd_i,
  input  tft_pkg::dp_stat_t   stat_i,
  output tft_pkg::ctl_cmd_t   cmd_o
);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_SRCH   = 11'b000_0000_0010,
    S_SZA    = 11'b000_0000_0100,
    S_SZB    = 11'b000_0000_1000,
    S_CR_WR  = 11'b000_0001_0000,
    S_REL_RD = 11'b000_0010_0000,
    S_REL_WR = 11'b000_0100_0000,
    S_CP_RD  = 11'b000_1000_0000,
    S_CP_DIM = 11'b001_0000_0000,
    S_CP_WR  = 11'b010_0000_0000,
    S_DONE   = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          case (in_cmd_i)
            tft_pkg::CMD_CREATE: state_d = S_SZA;
            tft_pkg::CMD_RELEASE, tft_pkg::CMD_COMPRESS: begin
              cmd_o.srch_start = 1'b1;
              state_d = S_SRCH;
            end
            default: begin
              cmd_o.zero_fin = 1'b1;
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_SRCH: begin
        cmd_o.srch_run = 1'b1;
        if (stat_i.srch_hit) begin
          state_d = (stat_i.cmd == tft_pkg::CMD_RELEASE) ? S_REL_RD : S_CP_RD;
        end else if (stat_i.srch_miss) begin
          cmd_o.miss_fin = 1'b1;
          state_d = S_DONE;
        end
      end
      S_REL_RD: begin
        cmd_o.rd_last = 1'b1;
        state_d = S_REL_WR;
      end
      S_REL_WR: begin
        cmd_o.rel_write = 1'b1;
        cmd_o.zero_fin  = 1'b1;
        state_d = S_DONE;
      end
      S_CP_RD: begin
        cmd_o.rd_rec = 1'b1;
        state_d = S_CP_DIM;
      end
      S_CP_DIM: begin
        cmd_o.cp_dim = 1'b1;
        state_d = S_SZA;
      end
      S_SZA: begin
        if (stat_i.sz_done) begin
          state_d = (stat_i.cmd == tft_pkg::CMD_CREATE) ? S_CR_WR : S_CP_WR;
        end else begin
          cmd_o.sz_step_a = 1'b1;
          state_d = S_SZB;
        end
      end
      S_SZB: begin
        cmd_o.sz_step_b = 1'b1;
        state_d = S_SZA;
      end
      S_CR_WR: begin
        cmd_o.create_fin = 1'b1;
        state_d = S_DONE;
      end
      S_CP_WR: begin
        cmd_o.cp_fin = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

endmodule

// File: sv/tft_dp.sv
// Datapath: entry table memories, id search, mip-chain size unit, result register.
// Depends on tft_pkg; commanded by tft_ctrl.
module tft_dp #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [14:0]         cfg_wdata_i,
  input  tft_pkg::in_item_t   in_item_i,
  input  tft_pkg::ctl_cmd_t   cmd_i,
  output tft_pkg::dp_stat_t   stat_o,
  output tft_pkg::out_item_t  out_item_o
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  // Configuration register
  logic [14:0] min_dim_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)       min_dim_q <= tft_pkg::MIN_DIM_RST;
    else if (cfg_we_i) min_dim_q <= cfg_wdata_i;
  end

  // Latched input item
  tft_pkg::in_item_t item_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) item_q <= in_item_i;
  end

  // Entry count
  logic [CW-1:0] count_q;
  logic          not_full;
  logic [AW-1:0] last_idx;
  assign not_full = count_q < DEPTH_C;
  assign last_idx = AW'(count_q - CW'(1));

  // Table memories
  logic [63:0]        id_mem [TABLE_DEPTH];
  tft_pkg::rec_t      rec_mem [TABLE_DEPTH];
  logic [63:0]        id_rdata_q;
  tft_pkg::rec_t      rec_rdata_q;
  logic [AW-1:0]      id_raddr, rec_raddr, waddr;
  logic               id_we, rec_we;
  logic [63:0]        id_wdata;
  tft_pkg::rec_t      rec_wdata;

  // Search state
  logic [CW-1:0] ptr_q;
  logic          pend_q;
  logic [AW-1:0] pidx_q, hit_idx_q;
  logic          match;
  assign match = pend_q && (id_rdata_q == item_q.tex_id);

  assign id_raddr  = cmd_i.srch_run ? ptr_q[AW-1:0] : last_idx;
  assign rec_raddr = cmd_i.rd_rec ? hit_idx_q : last_idx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q  <= '0;
      pend_q <= 1'b0;
    end else if (cmd_i.srch_start) begin
      ptr_q  <= '0;
      pend_q <= 1'b0;
    end else if (cmd_i.srch_run && !match) begin
      if (ptr_q < count_q) begin
        ptr_q  <= ptr_q + CW'(1);
        pend_q <= 1'b1;
      end else begin
        pend_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.srch_run) pidx_q <= ptr_q[AW-1:0];
    if (cmd_i.srch_run && match) hit_idx_q <= pidx_q;
  end

  // Size unit: each mip level takes a multiply step and then an accumulate step
  logic [14:0] w_q, h_q;
  logic [3:0]  mcnt_q, fmt_q;
  logic [11:0] arr_q;
  logic [29:0] prod_q;
  logic [47:0] acc_q;
  logic        is_bc8, is_bc16;
  logic [13:0] bw, bh;
  logic [14:0] ma, mb;
  logic [41:0] parr;
  logic [45:0] term;
  logic [2:0]  sh;
  logic [43:0] sz_sat;

  assign is_bc8  = (fmt_q == tft_pkg::FMT_BC1) || (fmt_q == tft_pkg::FMT_BC1B);
  assign is_bc16 = (fmt_q >= tft_pkg::FMT_BC2) && (fmt_q <= tft_pkg::FMT_BC_LAST);
  assign bw = 14'(({1'b0, w_q} + 16'd3) >> 2);
  assign bh = 14'(({1'b0, h_q} + 16'd3) >> 2);
  assign ma = (is_bc8 || is_bc16) ? {1'b0, bw} : w_q;
  assign mb = (is_bc8 || is_bc16) ? {1'b0, bh} : h_q;

  always_comb begin
    if (is_bc8 || fmt_q == tft_pkg::FMT_RGBA16F)       sh = 3'd3;
    else if (is_bc16 || fmt_q == tft_pkg::FMT_RGBA32F) sh = 3'd4;
    else                                               sh = 3'd2;
  end

  assign parr   = prod_q * arr_q;
  assign term   = {4'b0, parr} << sh;
  assign sz_sat = (acc_q > {4'b0, tft_pkg::SIZE_MAX}) ? tft_pkg::SIZE_MAX : acc_q[43:0];

  // Compress dimension and format choice
  logic [14:0] nw, nh;
  logic [3:0]  nf;
  logic [14:0] nw_q, nh_q;
  logic [3:0]  nf_q;
  tft_pkg::rec_t hold_q;
  logic        quarter;
  assign quarter = item_q.comp_level == tft_pkg::LVL_QUARTER;

  always_comb begin
    nf = rec_rdata_q.fmt;
    if (quarter) begin
      nw = tft_pkg::shrink(rec_rdata_q.w, 1'b1);
      nh = tft_pkg::shrink(rec_rdata_q.h, 1'b1);
    end else if (item_q.req_w != '0 && item_q.req_h != '0) begin
      nw = tft_pkg::round4(item_q.req_w);
      nh = tft_pkg::round4(item_q.req_h);
    end else begin
      nw = tft_pkg::shrink(rec_rdata_q.w, 1'b0);
      nh = tft_pkg::shrink(rec_rdata_q.h, 1'b0);
    end
    if ((rec_rdata_q.fmt == tft_pkg::FMT_RGBA8) || (rec_rdata_q.fmt == tft_pkg::FMT_BGRA8)) begin
      case (item_q.comp_level)
        tft_pkg::LVL_BC1: nf = tft_pkg::FMT_BC1;
        tft_pkg::LVL_BC3: nf = tft_pkg::FMT_BC3;
        tft_pkg::LVL_BC7: nf = tft_pkg::FMT_BC7;
        default:          nf = rec_rdata_q.fmt;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      w_q    <= in_item_i.width;
      h_q    <= in_item_i.height;
      mcnt_q <= in_item_i.mip_cnt;
      arr_q  <= in_item_i.slice_cnt;
      fmt_q  <= in_item_i.format;
      acc_q  <= '0;
    end else if (cmd_i.cp_dim) begin
      w_q    <= nw;
      h_q    <= nh;
      mcnt_q <= rec_rdata_q.mips;
      arr_q  <= rec_rdata_q.arr;
      fmt_q  <= nf;
      acc_q  <= '0;
      nw_q   <= nw;
      nh_q   <= nh;
      nf_q   <= nf;
      hold_q <= rec_rdata_q;
    end else if (cmd_i.sz_step_a) begin
      prod_q <= ma * mb;
    end else if (cmd_i.sz_step_b) begin
      acc_q  <= acc_q + 48'(term);
      w_q    <= (w_q > 15'd1) ? (w_q >> 1) : 15'd1;
      h_q    <= (h_q > 15'd1) ? (h_q >> 1) : 15'd1;
      mcnt_q <= mcnt_q - 4'd1;
    end
  end

  // Table writes
  always_comb begin
    id_we     = 1'b0;
    rec_we    = 1'b0;
    waddr     = hit_idx_q;
    id_wdata  = id_rdata_q;
    rec_wdata = rec_rdata_q;
    if (cmd_i.create_fin && not_full) begin
      id_we     = 1'b1;
      rec_we    = 1'b1;
      waddr     = count_q[AW-1:0];
      id_wdata  = item_q.tex_id;
      rec_wdata = '{comp: 4'd0, size: sz_sat, fmt: item_q.format,
                    arr: item_q.slice_cnt, mips: item_q.mip_cnt,
                    h: item_q.height, w: item_q.width};
    end else if (cmd_i.rel_write) begin
      id_we  = 1'b1;
      rec_we = 1'b1;
    end else if (cmd_i.cp_fin) begin
      rec_we    = 1'b1;
      rec_wdata = hold_q;
      rec_wdata.comp = {1'b1, item_q.comp_level};
    end
  end

  always_ff @(posedge clk_i) begin
    if (id_we)  id_mem[waddr]  <= id_wdata;
    if (rec_we) rec_mem[waddr] <= rec_wdata;
    id_rdata_q  <= id_mem[id_raddr];
    rec_rdata_q <= rec_mem[rec_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) count_q <= '0;
    else if (cmd_i.create_fin && not_full) count_q <= count_q + CW'(1);
    else if (cmd_i.rel_write)              count_q <= count_q - CW'(1);
  end

  // Result register
  tft_pkg::out_item_t out_q, out_d;
  always_comb begin
    out_d = out_q;
    if (cmd_i.zero_fin) begin
      out_d = '0;
    end else if (cmd_i.miss_fin) begin
      out_d        = '0;
      out_d.status = tft_pkg::ST_MISS;
    end else if (cmd_i.create_fin) begin
      out_d           = '0;
      out_d.status    = not_full ? tft_pkg::ST_OK : tft_pkg::ST_FULL;
      out_d.byte_size = sz_sat;
      out_d.candidate = (item_q.bind_bits == '0) && !item_q.cpu_write &&
                        (item_q.width >= min_dim_q) && (item_q.height >= min_dim_q);
    end else if (cmd_i.cp_fin) begin
      out_d.status      = tft_pkg::ST_OK;
      out_d.byte_size   = hold_q.size;
      out_d.candidate   = 1'b0;
      out_d.new_width   = nw_q;
      out_d.new_height  = nh_q;
      out_d.new_format  = nf_q;
      out_d.comp_size   = sz_sat;
      out_d.saved_bytes = (hold_q.size > sz_sat) ? (hold_q.size - sz_sat) : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_item_o       = out_q;
  assign stat_o.cmd       = item_q.cmd;
  assign stat_o.srch_hit  = match;
  assign stat_o.srch_miss = !match && (ptr_q >= count_q);
  assign stat_o.sz_done   = mcnt_q == 4'd0;

endmodule

// File: sv/texture_footprint_tracker.sv
// Texture footprint tracker top level: one item in flight at a time.
// Steps to result valid: create sizes the mip chain and writes the entry; release and
// compress first scan the table at one entry a cycle (a miss ends there), then release
// moves the last entry into the hit slot and compress resizes the mip chain and writes.
// Throughput: the next item is taken the cycle after its result is accepted.
// Reset clears the entry count and sets min_candidate_dim to 64; table is not cleared.
module texture_footprint_tracker #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tft_in_if.sink      in_i,
  tft_out_if.source   out_o,
  input  logic        cfg_we_i,
  input  logic [14:0] cfg_wdata_i
);

  tft_pkg::ctl_cmd_t ctl_cmd;
  tft_pkg::dp_stat_t dp_stat;

  // Sequencer
  tft_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .in_cmd_i    (in_i.item.cmd),
    .stat_i      (dp_stat),
    .cmd_o       (ctl_cmd)
  );

  // Table, search and size arithmetic
  tft_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_item_i   (in_i.item),
    .cmd_i       (ctl_cmd),
    .stat_o      (dp_stat),
    .out_item_o  (out_o.item)
  );

  // No item is taken while a result is pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.valid && in_i.ready && out_o.valid))
    else $error("item accepted while result pending");

  // Status code is never the unused one
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.item.status != tft_pkg::ST_UNUSED)
    else $error("bad status");

  // A miss carries no sizes
  a_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.item.status == tft_pkg::ST_MISS) |->
      (out_o.item.byte_size == '0 && out_o.item.comp_size == '0))
    else $error("miss with size");

  // Saved bytes never exceed the old size
  a_saved: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.item.saved_bytes <= out_o.item.byte_size)
    else $error("saved exceeds size");

endmodule

// File: dv/tb_top.sv
// Testbench for the texture footprint tracker: random and directed commands with
// a built-in table predictor. Depends on tft_pkg, tft_if and the tracker RTL.
module tb_top;

  localparam int DEPTH = 1024;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [14:0] cfg_wdata_i;

  tft_in_if  cmd_ch ();
  tft_out_if res_ch ();

  texture_footprint_tracker #(.TABLE_DEPTH(DEPTH)) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (cmd_ch.sink),
    .out_o       (res_ch.source),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Clock
  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  // Predictor state
  logic [14:0]   mdl_min_dim;
  int            mdl_count;
  logic [63:0]   mdl_ids  [DEPTH];
  tft_pkg::rec_t mdl_recs [DEPTH];

  tft_pkg::in_item_t  pending_cmds [$];
  tft_pkg::out_item_t expected_res [$];
  int          idle_pct, stall_pct;
  int          n_errors, n_checked, n_sent;
  logic [63:0] id_pool [$];

  // Full mip-chain byte size, saturated to 44 bits
  function automatic logic [43:0] mip_chain_bytes(logic [14:0] w0, logic [14:0] h0,
      logic [3:0] mips, logic [11:0] arr, logic [3:0] fmt);
    logic [63:0] total, lvl, blocks, pix, w, h;
    total = '0; w = 64'(w0); h = 64'(h0);
    for (int m = 0; m < mips; m++) begin
      blocks = ((w + 64'd3) / 64'd4) * ((h + 64'd3) / 64'd4);
      pix = w * h;
      if (fmt == tft_pkg::FMT_BC1 || fmt == tft_pkg::FMT_BC1B) lvl = blocks * 64'd8;
      else if (fmt >= tft_pkg::FMT_BC2 && fmt <= tft_pkg::FMT_BC_LAST) lvl = blocks * 64'd16;
      else if (fmt == tft_pkg::FMT_RGBA16F) lvl = pix * 64'd8;
      else if (fmt == tft_pkg::FMT_RGBA32F) lvl = pix * 64'd16;
      else lvl = pix * 64'd4;
      total += lvl * 64'(arr);
      w = (w > 64'd1) ? (w >> 1) : 64'd1;
      h = (h > 64'd1) ? (h >> 1) : 64'd1;
    end
    return (total > 64'(tft_pkg::SIZE_MAX)) ? tft_pkg::SIZE_MAX : total[43:0];
  endfunction

  function automatic logic [14:0] round_up4(int v);
    int r;
    r = (v + 3) & ~3;
    return (r > int'(tft_pkg::DIM_SAT)) ? tft_pkg::DIM_SAT : r[14:0];
  endfunction

  function automatic logic [14:0] shrink_dim(logic [14:0] v, int div);
    logic [14:0] r;
    r = round_up4(int'(v) / div);
    return (r < tft_pkg::DIM_MIN) ? tft_pkg::DIM_MIN : r;
  endfunction

  function automatic int lookup(logic [63:0] id);
    for (int i = 0; i < mdl_count; i++)
      if (mdl_ids[i] == id) return i;
    return -1;
  endfunction

  // Apply one accepted command to the table and queue its result
  task automatic track_command(tft_pkg::in_item_t c);
    tft_pkg::out_item_t r;
    tft_pkg::rec_t      e;
    int                 k;
    logic [43:0]        ns;
    r = '0;
    case (tft_pkg::cmd_e'(c.cmd))
      tft_pkg::CMD_CREATE: begin
        r.byte_size = mip_chain_bytes(c.width, c.height, c.mip_cnt, c.slice_cnt,
                                      c.format);
        r.candidate = (c.bind_bits == '0) && !c.cpu_write &&
                      c.width >= mdl_min_dim && c.height >= mdl_min_dim;
        if (mdl_count >= DEPTH) r.status = tft_pkg::ST_FULL;
        else begin
          e = '0;
          e.w = c.width; e.h = c.height; e.mips = c.mip_cnt;
          e.arr = c.slice_cnt; e.fmt = c.format; e.size = r.byte_size;
          mdl_ids[mdl_count] = c.tex_id;
          mdl_recs[mdl_count] = e;
          mdl_count++;
        end
      end
      tft_pkg::CMD_RELEASE: begin
        k = lookup(c.tex_id);
        if (k < 0) r.status = tft_pkg::ST_MISS;
        else begin
          mdl_ids[k] = mdl_ids[mdl_count-1];
          mdl_recs[k] = mdl_recs[mdl_count-1];
          mdl_count--;
        end
      end
      tft_pkg::CMD_COMPRESS: begin
        k = lookup(c.tex_id);
        if (k < 0) r.status = tft_pkg::ST_MISS;
        else begin
          e = mdl_recs[k];
          r.new_format = e.fmt;
          if (c.req_w != '0 && c.req_h != '0) begin
            r.new_width = round_up4(int'(c.req_w));
            r.new_height = round_up4(int'(c.req_h));
          end else begin
            r.new_width = shrink_dim(e.w, 2);
            r.new_height = shrink_dim(e.h, 2);
          end
          if (c.comp_level <= tft_pkg::LVL_BC7) begin
            if (e.fmt == tft_pkg::FMT_RGBA8 || e.fmt == tft_pkg::FMT_BGRA8)
              r.new_format = (c.comp_level == tft_pkg::LVL_BC1) ? tft_pkg::FMT_BC1 :
                             (c.comp_level == tft_pkg::LVL_BC3) ? tft_pkg::FMT_BC3 :
                                                                  tft_pkg::FMT_BC7;
          end else if (c.comp_level == tft_pkg::LVL_QUARTER) begin
            r.new_width = shrink_dim(e.w, 4);
            r.new_height = shrink_dim(e.h, 4);
          end
          ns = mip_chain_bytes(r.new_width, r.new_height, e.mips, e.arr, r.new_format);
          r.byte_size = e.size;
          r.comp_size = ns;
          r.saved_bytes = (e.size > ns) ? e.size - ns : '0;
          mdl_recs[k].comp = {1'b1, c.comp_level};
        end
      end
      default: ;
    endcase
    expected_res.push_back(r);
  endtask

  // Driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_ch.valid <= 1'b0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        track_command(cmd_ch.item);
        n_sent++;
      end
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= idle_pct) begin
          cmd_ch.item  <= pending_cmds.pop_front();
          cmd_ch.valid <= 1'b1;
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor and result check
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_res.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("ERROR: unexpected result %p", res_ch.item);
        end else begin
          tft_pkg::out_item_t x;
          x = expected_res.pop_front();
          n_checked++;
          if (res_ch.item !== x) begin
            n_errors++;
            if (n_errors <= 10)
              $display("ERROR: result %0d\n  expected %p\n  actual   %p",
                       n_checked, x, res_ch.item);
          end
        end
      end
      res_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Random command; ids mostly from a small pool so lookups hit
  function automatic tft_pkg::in_item_t rand_cmd();
    tft_pkg::in_item_t c;
    int sel;
    c.cmd = ($urandom_range(99) < 45) ? tft_pkg::CMD_CREATE :
            ($urandom_range(1) ? tft_pkg::CMD_RELEASE : tft_pkg::CMD_COMPRESS);
    if ($urandom_range(99) < 2) c.cmd = tft_pkg::CMD_NONE;
    sel = $urandom_range(99);
    c.tex_id = (sel < 85) ? id_pool[$urandom_range(id_pool.size()-1)]
                          : {$urandom, $urandom};
    // Mostly modest sizes, occasionally the extremes
    if ($urandom_range(9) == 0) begin
      c.width = 15'($urandom_range(16384, 1)); c.height = 15'($urandom_range(16384, 1));
      c.slice_cnt = 12'($urandom_range(2048, 1));
    end else begin
      c.width = 15'($urandom_range(300, 1)); c.height = 15'($urandom_range(300, 1));
      c.slice_cnt = 12'($urandom_range(8, 1));
    end
    c.mip_cnt = 4'($urandom_range(15, 1));
    c.format = 4'($urandom_range(15));
    c.bind_bits = ($urandom_range(1)) ? 3'd0 : 3'($urandom_range(7));
    c.cpu_write = ($urandom_range(3) == 0);
    c.comp_level = 3'($urandom_range(7));
    if ($urandom_range(1)) begin
      c.req_w = 15'($urandom_range(16384)); c.req_h = 15'($urandom_range(16384));
    end else begin
      c.req_w = '0; c.req_h = '0;
    end
    return c;
  endfunction

  function automatic tft_pkg::in_item_t make_create(logic [63:0] id, int w, int h,
      int mips, int arr, int fmt, int bnd, int cpuw);
    tft_pkg::in_item_t c;
    c = '0;
    c.cmd = tft_pkg::CMD_CREATE; c.tex_id = id; c.width = 15'(w); c.height = 15'(h);
    c.mip_cnt = 4'(mips); c.slice_cnt = 12'(arr); c.format = 4'(fmt);
    c.bind_bits = 3'(bnd); c.cpu_write = 1'(cpuw);
    return c;
  endfunction

  function automatic tft_pkg::in_item_t make_lookup(tft_pkg::cmd_e op, logic [63:0] id,
      int lvl, int tw, int th);
    tft_pkg::in_item_t c;
    c = '0;
    c.cmd = op; c.tex_id = id; c.comp_level = 3'(lvl);
    c.req_w = 15'(tw); c.req_h = 15'(th);
    return c;
  endfunction

  task automatic drain_and_config(logic [14:0] v);
    while (pending_cmds.size() != 0 || cmd_ch.valid || expected_res.size() != 0)
      @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    mdl_min_dim = v;
  endtask

  // Stimulus
  initial begin
    tft_pkg::in_item_t c;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_wdata_i = '0;
    cmd_ch.valid = 1'b0; cmd_ch.item = '0;
    res_ch.ready = 1'b0;
    idle_pct = 0; stall_pct = 0;
    n_errors = 0; n_checked = 0; n_sent = 0;
    mdl_min_dim = tft_pkg::MIN_DIM_RST; mdl_count = 0;
    for (int i = 0; i < 12; i++) id_pool.push_back({$urandom, $urandom});
    id_pool.push_back('0); id_pool.push_back('1);
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, every format class, duplicates, misses, unused command
    pending_cmds.push_back(make_create('1, 16384, 16384, 15, 2048, 13, 0, 0));
    pending_cmds.push_back(make_create('0, 1, 1, 1, 1, 0, 7, 1));
    pending_cmds.push_back(make_create(64'h5, 64, 64, 7, 1, 9, 0, 0));
    pending_cmds.push_back(make_create(64'h5, 63, 64, 3, 2, 11, 0, 0));
    pending_cmds.push_back(make_create(64'h6, 130, 70, 8, 3, 1, 0, 0));
    pending_cmds.push_back(make_create(64'h7, 5, 9, 4, 1, 5, 2, 0));
    pending_cmds.push_back(make_create(64'h8, 200, 33, 15, 4, 12, 4, 0));
    pending_cmds.push_back(make_create(64'h9, 3, 3, 2, 1, 10, 1, 0));
    pending_cmds.push_back(make_lookup(tft_pkg::CMD_COMPRESS, 64'h5, 0, 0, 0));
    pending_cmds.push_back(make_lookup(tft_pkg::CMD_COMPRESS, 64'h5, 1, 16384, 1));
    pending_cmds.push_back(make_lookup(tft_pkg::CMD_COMPRESS, 64'h5, 2, 0, 500));
    pending_cmds.push_back(make_lookup(tft_pkg::CMD_COMPRESS, 64'h5, 3, 100, 100));
    pending_cmds.push_back(make_lookup(tft_pkg::CMD_COMPRESS, 64'h9, 7, 0, 0));
    pending_cmds.push_back(make_lookup(tft_pkg::CMD_COMPRESS, '1, 4, 32767, 32767));
    pending_cmds.push_back(make_lookup(tft_pkg::CMD_COMPRESS, 64'h8, 2, 0, 0));
    pending_cmds.push_back(make_lookup(tft_pkg::CMD_RELEASE, 64'h5, 0, 0, 0));
    pending_cmds.push_back(make_lookup(tft_pkg::CMD_COMPRESS, 64'h5, 0, 0, 0));
    pending_cmds.push_back(make_lookup(tft_pkg::CMD_RELEASE, 64'h1234, 0, 0, 0));
    pending_cmds.push_back(make_lookup(tft_pkg::CMD_COMPRESS, 64'h1234, 0, 0, 0));
    pending_cmds.push_back(make_lookup(tft_pkg::CMD_NONE, 64'h6, 5, 3, 3));
    pending_cmds.push_back(make_lookup(tft_pkg::CMD_RELEASE, '0, 0, 0, 0));
    drain_and_config(15'd1);

    // Random phases across idle/stall mixes and register settings
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = (ph == 1 || ph == 3) ? (ph == 1 ? 71 : 12) : 0;
      stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 71 : 12) : 0;
      repeat (110) pending_cmds.push_back(rand_cmd());
      drain_and_config(ph == 0 ? 15'd16384 : 15'($urandom_range(300, 1)));
    end

    // Grow the table so searches run long, then mix in more random commands
    idle_pct = 0; stall_pct = 0;
    repeat (60) begin
      c = make_create({$urandom, $urandom}, $urandom_range(8, 1), $urandom_range(8, 1),
                      1, 1, $urandom_range(15), 0, 0);
      pending_cmds.push_back(c);
    end
    repeat (20) pending_cmds.push_back(rand_cmd());
    drain_and_config(tft_pkg::MIN_DIM_RST);

    $display("Sent %0d commands, checked %0d results across 4 handshake mixes,",
             n_sent, n_checked);
    $display("with long table scans and min dim settings from 1 to 16384.");
    if (n_errors == 0 && expected_res.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #50000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// File: filelist.f
sv/tft_pkg.sv
sv/tft_if.sv
sv/tft_ctrl.sv
sv/tft_dp.sv
sv/texture_footprint_tracker.sv
dv/tb_top.sv
